// ----- rtl/crcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_pkg
// Shared types and constants of the CRC codeword packer.
// ----------------------------------------------------------------------------
package crcp_pkg;

	localparam int DATA_W      = 8;
	localparam int ACC_W       = 48;   // bits of one job and of the back accumulator
	localparam int NBITS_W     = 6;    // holds 0..48
	localparam int REM_W       = 16;   // longest remainder
	localparam int POLY_W      = 17;
	localparam int GLEN_W      = 5;
	localparam int BCNT_W      = 24;
	localparam int PAD_W       = 4;    // pad count 1..8
	localparam int MAX_GEN_LEN = 17;
	localparam int HARD_CAP    = 17;
	localparam int GEN_CAP     = (MAX_GEN_LEN < HARD_CAP) ? MAX_GEN_LEN : HARD_CAP;

	localparam logic              RST_MODE = 1'b1;
	localparam logic [POLY_W-1:0] RST_POLY = 17'd13;
	localparam logic [GLEN_W-1:0] RST_GLEN = 5'd4;
	localparam logic [BCNT_W-1:0] RST_BCNT = 24'd1;

	typedef enum logic [1:0] {
		CFG_MODE = 2'd0,
		CFG_POLY = 2'd1,
		CFG_GLEN = 2'd2,
		CFG_BCNT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic              mode;   // 1 = 8-bit datawords
		logic [POLY_W-1:0] poly;
		logic [GLEN_W-1:0] glen;
		logic [BCNT_W-1:0] bcnt;
	} cfg_t;

	// One classified input byte: bits to append, right aligned.
	typedef struct packed {
		logic               hdr;    // first byte of a stream
		logic [PAD_W-1:0]   pad;
		logic [ACC_W-1:0]   bits;
		logic [NBITS_W-1:0] nbits;
		logic               eos;    // last byte of a stream
	} job_t;

endpackage

// ----- rtl/crcp_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp channel interfaces
// Input byte, output word and configuration write channels.
// ----------------------------------------------------------------------------
interface crcp_in_if;
	import crcp_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface crcp_out_if;
	import crcp_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] out_byte;
	logic              is_header;
	logic              run_last;
	logic              stream_last;
	modport source (output valid, output out_byte, output is_header, output run_last,
		output stream_last, input ready);
	modport sink   (input valid, input out_byte, input is_header, input run_last,
		input stream_last, output ready);
endinterface

interface crcp_cfg_if;
	import crcp_pkg::*;
	logic              valid;
	logic              ready;
	cfg_idx_t          index;
	logic [BCNT_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/crcp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_front
// Takes input bytes, computes the remainders and builds one job per byte.
// ----------------------------------------------------------------------------
module crcp_front (
	input  logic            clk,
	input  logic            arst_n,
	crcp_in_if.sink         items,
	input  crcp_pkg::cfg_t  cfg_r,
	input  logic            q_ready,
	output logic            push,
	output crcp_pkg::job_t  push_job
);
	import crcp_pkg::*;

	logic [BCNT_W-1:0] seen_q;
	logic [BCNT_W-1:0] seen_nxt;
	logic [GLEN_W-1:0] g;
	logic [GLEN_W-1:0] rl;
	logic [3:0]        tb;
	logic [REM_W-1:0]  mask;
	logic [REM_W-1:0]  poly;
	logic [REM_W-1:0]  c8, chi, clo;
	logic [ACC_W-1:0]  cw_hi, cw_lo;
	logic [2:0]        len3;
	logic [5:0]        prod;
	logic [PAD_W-1:0]  pad;
	logic              hdr;
	logic              eos;

	// Serial remainder over up to eight dataword bits, MSB first.
	function automatic logic [REM_W-1:0] crc_calc(input logic [7:0] w,
		input logic [3:0] nsteps, input logic [REM_W-1:0] p,
		input logic [REM_W-1:0] m, input logic [3:0] top);
		logic [REM_W-1:0] r;
		logic             t;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < nsteps) begin
				t = r[top] ^ w[7-i];
				r = (r << 1) & m;
				if (t) begin
					r = r ^ p;
				end
			end
		end
		return r;
	endfunction

	always_comb begin
		if (cfg_r.glen < 5'd2) begin
			g = 5'd2;
		end else if (cfg_r.glen > 5'(GEN_CAP)) begin
			g = 5'(GEN_CAP);
		end else begin
			g = cfg_r.glen;
		end
		rl   = g - 5'd1;
		tb   = 4'(rl - 5'd1);
		mask = REM_W'((17'd1 << rl) - 17'd1);
		poly = cfg_r.poly[REM_W-1:0] & mask;

		c8  = crc_calc(items.data_byte, 4'd8, poly, mask, tb);
		chi = crc_calc({items.data_byte[7:4], 4'h0}, 4'd4, poly, mask, tb);
		clo = crc_calc({items.data_byte[3:0], 4'h0}, 4'd4, poly, mask, tb);

		cw_hi = (ACC_W'(items.data_byte[7:4]) << rl) | ACC_W'(chi);
		cw_lo = (ACC_W'(items.data_byte[3:0]) << rl) | ACC_W'(clo);

		// Codeword bits per byte modulo 8, then the pad count.
		len3 = cfg_r.mode ? rl[2:0] : {rl[1:0], 1'b0};
		prod = 6'(cfg_r.bcnt[2:0]) * 6'(len3);
		pad  = 4'd8 - {1'b0, prod[2:0]};

		hdr      = (seen_q == '0);
		seen_nxt = seen_q + BCNT_W'(1);
		eos      = (seen_nxt == cfg_r.bcnt);

		push_job.hdr = hdr;
		push_job.pad = pad;
		push_job.eos = eos;
		if (cfg_r.mode) begin
			push_job.bits  = (ACC_W'(items.data_byte) << rl) | ACC_W'(c8);
			push_job.nbits = 6'd8 + 6'(rl) + (hdr ? 6'(pad) : 6'd0);
		end else begin
			push_job.bits  = (cw_hi << (5'd4 + rl)) | cw_lo;
			push_job.nbits = 6'd8 + 6'({rl, 1'b0}) + (hdr ? 6'(pad) : 6'd0);
		end
	end

	assign items.ready = q_ready;
	assign push        = items.valid & q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (push) begin
			seen_q <= eos ? '0 : seen_nxt;
		end
	end

endmodule

// ----- rtl/crcp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module crcp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  crcp_pkg::job_t  push_job,
	output logic            q_ready,
	output logic            head_valid,
	input  logic            pop,
	output crcp_pkg::job_t  head
);
	import crcp_pkg::*;

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign q_ready    = (cnt_q != 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ----- rtl/crcp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_back
// Bit accumulator: loads jobs and sends out header and packed words.
// ----------------------------------------------------------------------------
module crcp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	input  crcp_pkg::job_t  job,
	output logic            job_ready,
	crcp_out_if.source      codes
);
	import crcp_pkg::*;

	logic               busy_q, hdr_q, eos_q;
	logic [PAD_W-1:0]   pad_q;
	logic [ACC_W-1:0]   acc_q;
	logic [NBITS_W-1:0] held_q;
	logic               ov_q;
	logic [DATA_W-1:0]  byte_q;
	logic               ishdr_q, rlast_q, slast_q;

	logic               have_byte, have_flush, emit_any, emit_fire, emit_last, done, load;
	logic [NBITS_W-1:0] held_a;
	logic               hdr_a;
	logic [DATA_W-1:0]  emit_byte;
	logic [ACC_W-1:0]   drain_sh;

	always_comb begin
		have_byte  = (held_q >= 6'd8);
		have_flush = eos_q && (held_q != '0);
		emit_any   = busy_q && (hdr_q || have_byte || have_flush);
		emit_fire  = emit_any && (!ov_q || codes.ready);
		drain_sh   = acc_q >> (held_q - 6'd8);

		hdr_a     = hdr_q;
		held_a    = held_q;
		emit_byte = {4'h0, pad_q};
		if (hdr_q) begin
			emit_byte = {4'h0, pad_q};
			if (emit_fire) begin
				hdr_a = 1'b0;
			end
		end else if (have_byte) begin
			emit_byte = drain_sh[DATA_W-1:0];
			if (emit_fire) begin
				held_a = held_q - 6'd8;
			end
		end else begin
			emit_byte = acc_q[DATA_W-1:0] << (4'd8 - held_q[3:0]);
			if (emit_fire) begin
				held_a = '0;
			end
		end

		emit_last = !hdr_a && (held_a < 6'd8) && !(eos_q && (held_a != '0));
		done      = busy_q && (!emit_any || (emit_fire && emit_last));
		load      = job_valid && (!busy_q || done);
	end

	assign job_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			hdr_q  <= 1'b0;
			eos_q  <= 1'b0;
			held_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				hdr_q  <= job.hdr;
				eos_q  <= job.eos;
				held_q <= job.hdr ? job.nbits : held_a + job.nbits;
			end else begin
				if (done) begin
					busy_q <= 1'b0;
				end
				hdr_q  <= hdr_a;
				held_q <= held_a;
			end
			if (emit_fire) begin
				ov_q <= 1'b1;
			end else if (codes.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pad_q <= job.pad;
			acc_q <= job.hdr ? job.bits : ((acc_q << job.nbits) | job.bits);
		end
		if (emit_fire) begin
			byte_q  <= emit_byte;
			ishdr_q <= hdr_q;
			rlast_q <= emit_last;
			slast_q <= emit_last && eos_q;
		end
	end

	assign codes.valid       = ov_q;
	assign codes.out_byte    = byte_q;
	assign codes.is_header   = ishdr_q;
	assign codes.run_last    = rlast_q;
	assign codes.stream_last = slast_q;

endmodule

// ----- rtl/crc_codeword_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_codeword_packer
// CRC encoder with a programmable generator, packing codewords into bytes.
// ----------------------------------------------------------------------------
// Usage:
//   items : one file byte per word, split MSB first into 4- or 8-bit datawords.
//   codes : packed output bytes; the first word of each stream is the pad
//           count header (is_header), run_last marks the final word caused
//           by an input byte, stream_last the final word of the stream.
//           Every input byte causes at least one output word.
//   cfg   : register writes (mode, generator, generator length, byte count),
//           always ready; write only while the block is idle.
// Path: the job is queued at the accepting edge and loaded at the next when
//   idle; the first word then goes through the output register to codes.
// Throughput: while codes is ready, the back end sends one word per cycle and
//   loads the next job in the cycle of the last word of the current one.
// Reset: stream counter cleared, so the next byte opens a stream with a
//   header; registers take their default values.
// Stall: while codes is not ready the output register holds its word; the
//   two-entry queue fills and then items.ready drops.
// ----------------------------------------------------------------------------
module crc_codeword_packer (
	input  logic        clk,
	input  logic        arst_n,
	crcp_in_if.sink     items,
	crcp_out_if.source  codes,
	crcp_cfg_if.sink    cfg
);
	import crcp_pkg::*;

	cfg_t cfg_q;
	logic push, q_ready, head_valid, pop;
	job_t push_job, head;

	// Configuration registers: writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= RST_MODE;
			cfg_q.poly <= RST_POLY;
			cfg_q.glen <= RST_GLEN;
			cfg_q.bcnt <= RST_BCNT;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MODE: cfg_q.mode <= cfg.data[0];
				CFG_POLY: cfg_q.poly <= cfg.data[POLY_W-1:0];
				CFG_GLEN: cfg_q.glen <= cfg.data[GLEN_W-1:0];
				CFG_BCNT: cfg_q.bcnt <= cfg.data;
				default: ;
			endcase
		end
	end

	// Front end: remainders, stream position, header decision.
	crcp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.cfg_r    (cfg_q),
		.q_ready  (q_ready),
		.push     (push),
		.push_job (push_job)
	);

	// Decouples the front end from output stalls.
	crcp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.q_ready    (q_ready),
		.head_valid (head_valid),
		.pop        (pop),
		.head       (head)
	);

	// Back end: bit accumulator and output register.
	crcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (head_valid),
		.job       (head),
		.job_ready (pop),
		.codes     (codes)
	);

`ifndef NO_ASSERTIONS
	// A header word always has more words after it for the same byte.
	a_hdr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		codes.valid && codes.is_header |-> !codes.run_last)
		else $error("header word marked as last of its byte");

	// The end of a stream is also the end of the byte that closed it.
	a_slast_rlast: assert property (@(posedge clk) disable iff (!arst_n)
		codes.valid && codes.stream_last |-> codes.run_last)
		else $error("stream_last without run_last");

	// Pad count lies in 1..8.
	a_pad_range: assert property (@(posedge clk) disable iff (!arst_n)
		codes.valid && codes.is_header |-> (codes.out_byte != 8'd0 && codes.out_byte <= 8'd8))
		else $error("header pad count out of range");

	// The queue is never written while full.
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready |-> push && q_ready)
		else $error("byte accepted without queue room");
`endif

endmodule
